/* rtl/char_lcd_terminal_scroller_unit_assert.svh */
// assertion macros shared by the character lcd terminal rtl
// expects clk and arst_n in the scope of each use; NO_ASSERTIONS removes them
`ifndef CHAR_LCD_TERMINAL_SCROLLER_UNIT_ASSERT_SVH
`define CHAR_LCD_TERMINAL_SCROLLER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CLTS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CLTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CLTS_ASSERT_IMPL(label, ante, cons, msg)
`define CLTS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

/* rtl/clts_pkg.sv */
// shared constants and controller/datapath interface types
// for the character lcd terminal; no dependencies
package clts_pkg;

	localparam int COLUMNS   = 16;
	localparam int ROWS      = 2;
	localparam int RAM_DEPTH = 128;

	localparam int ADDR_W     = $clog2(RAM_DEPTH);
	localparam int COL_W      = $clog2(COLUMNS + 1);
	localparam int ROW_W      = (ROWS == 1) ? 1 : $clog2(2 * ROWS);
	localparam int ROW_MAX    = 2 * ROWS - 1;
	localparam int X_W        = (COLUMNS == 1) ? 1 : $clog2(COLUMNS);
	localparam int Y_W        = $clog2(ROWS + 1);
	localparam int SUM_W      = ROW_W + 2;
	localparam int NUM_LINES  = 4;
	localparam int LINE_IDX_W = 2;
	localparam int CFG_IDX_W  = 8;
	localparam int BYTE_W     = 8;

	localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;
	localparam logic [BYTE_W-1:0] CMD_CLEAR    = 8'h01;
	localparam logic [BYTE_W-1:0] CMD_SET_ADDR = 8'h80;
	localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0A;

	localparam logic [ADDR_W-1:0] LINE_START_RST [NUM_LINES] = '{7'd0, 7'd64, 7'd20, 7'd84};

	typedef enum logic [1:0] {
		OUT_SETADDR,
		OUT_CLEAR,
		OUT_COPY,
		OUT_CHAR
	} out_sel_t;

	typedef enum logic [1:0] {
		LS_ROW,
		LS_Y,
		LS_SRC,
		LS_LAST
	} line_sel_t;

	typedef struct packed {
		logic      cap_char;
		logic      adv;
		logic      home;
		logic      emit;
		out_sel_t  sel;
		logic      last;
		line_sel_t line_sel;
		logic      clr_all;
		logic      rd_en;
		logic      blank_wr;
		logic      y_clr;
		logic      y_inc;
		logic      x_clr;
		logic      x_inc;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_nl;
		logic col_full;
		logic row_below;
		logic row_far;
		logic y_done;
		logic copy_row;
		logic x_last;
		logic out_free;
	} dp_sts_t;

endpackage

/* rtl/char_lcd_terminal_scroller_unit.sv */
// top level of the character lcd terminal: controller plus datapath
// depends on clts_pkg, clts_ctrl and clts_dpath
//
// Takes one character per request and produces the LCD bytes that show it on a
// ROWS x COLUMNS terminal. One character is handled at a time. The request is
// accepted in an idle cycle. A printable character that wraps to the next row,
// and a newline, first send the set address of that row unless it lies below
// the screen. A character may also lead to a clear of the whole screen or to a
// scroll. A scroll clears the display and then recopies each kept row from the
// shadow display RAM. Each copied byte is a registered read and then the write.
// Each dropped row is blanked in the shadow RAM. Every output stall holds the
// sequence. The shadow RAM reads as spaces after reset, with no clearing pass.
// Line start registers 0 to 3 are written over the cfg port, which is always
// ready.

module char_lcd_terminal_scroller_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           char_valid,
	output logic                           char_stall,
	input  logic [clts_pkg::BYTE_W-1:0]    char_code,
	output logic                           lcd_valid,
	input  logic                           lcd_stall,
	output logic                           reg_select,
	output logic [clts_pkg::BYTE_W-1:0]    lcd_byte,
	output logic                           long_wait,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [clts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clts_pkg::ADDR_W-1:0]    cfg_data
);

	clts_pkg::ctrl_cmd_t cmd;
	clts_pkg::dp_sts_t   sts;

	assign cfg_ready = 1'b1;

	clts_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	clts_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.char_code  (char_code),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.lcd_stall  (lcd_stall),
		.lcd_valid  (lcd_valid),
		.reg_select (reg_select),
		.lcd_byte   (lcd_byte),
		.long_wait  (long_wait),
		.last       (last)
	);

endmodule

/* rtl/clts_ctrl.sv */
// sequencing state machine for the character lcd terminal
// depends on clts_pkg and the assertion macro header
`include "char_lcd_terminal_scroller_unit_assert.svh"

module clts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  clts_pkg::dp_sts_t   sts,
	output clts_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_ADV,
		S_ADV_SET,
		S_CHECK,
		S_CLR_FULL,
		S_SC_CLEAR,
		S_SC_ROW,
		S_SC_SET,
		S_SC_RD,
		S_SC_WR,
		S_SC_BLANK,
		S_SET_LAST,
		S_WRITE
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd        = '0;
		state_d    = state_q;
		char_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (char_valid) begin
					cmd.cap_char = 1'b1;
					state_d      = S_START;
				end
			end
			S_START: begin
				state_d = (sts.is_nl || sts.col_full) ? S_ADV : S_CHECK;
			end
			S_ADV: begin
				cmd.adv = 1'b1;
				state_d = S_ADV_SET;
			end
			S_ADV_SET: begin
				cmd.line_sel = clts_pkg::LS_ROW;
				if (sts.row_below) begin
					state_d = sts.is_nl ? S_IDLE : S_CHECK;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = clts_pkg::OUT_SETADDR;
					cmd.last = sts.is_nl;
					state_d  = sts.is_nl ? S_IDLE : S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.row_far) begin
					state_d = S_CLR_FULL;
				end else if (sts.row_below) begin
					state_d = S_SC_CLEAR;
				end else begin
					state_d = S_WRITE;
				end
			end
			S_CLR_FULL: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.sel     = clts_pkg::OUT_CLEAR;
					cmd.clr_all = 1'b1;
					state_d     = S_SET_LAST;
				end
			end
			S_SC_CLEAR: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = clts_pkg::OUT_CLEAR;
					cmd.y_clr = 1'b1;
					state_d   = S_SC_ROW;
				end
			end
			S_SC_ROW: begin
				if (sts.y_done) begin
					state_d = S_SET_LAST;
				end else if (sts.copy_row) begin
					state_d = S_SC_SET;
				end else begin
					cmd.x_clr = 1'b1;
					state_d   = S_SC_BLANK;
				end
			end
			S_SC_SET: begin
				cmd.line_sel = clts_pkg::LS_Y;
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					cmd.sel   = clts_pkg::OUT_SETADDR;
					cmd.x_clr = 1'b1;
					state_d   = S_SC_RD;
				end
			end
			S_SC_RD: begin
				cmd.line_sel = clts_pkg::LS_SRC;
				cmd.rd_en    = 1'b1;
				state_d      = S_SC_WR;
			end
			S_SC_WR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = clts_pkg::OUT_COPY;
					if (sts.x_last) begin
						cmd.y_inc = 1'b1;
						state_d   = S_SC_ROW;
					end else begin
						cmd.x_inc = 1'b1;
						state_d   = S_SC_RD;
					end
				end
			end
			S_SC_BLANK: begin
				cmd.line_sel = clts_pkg::LS_Y;
				cmd.blank_wr = 1'b1;
				if (sts.x_last) begin
					cmd.y_inc = 1'b1;
					state_d   = S_SC_ROW;
				end else begin
					cmd.x_inc = 1'b1;
				end
			end
			S_SET_LAST: begin
				cmd.line_sel = clts_pkg::LS_LAST;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = clts_pkg::OUT_SETADDR;
					cmd.home = 1'b1;
					state_d  = S_WRITE;
				end
			end
			S_WRITE: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = clts_pkg::OUT_CHAR;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`CLTS_ASSERT_IMPL(a_emit_needs_room, cmd.emit, sts.out_free, "byte pushed into a full output register")
	`CLTS_ASSERT_NEXT(a_read_then_copy, cmd.rd_en, state_q == S_SC_WR, "shadow read not followed by its copy")

endmodule

/* rtl/clts_dpath.sv */
// datapath: cursor, write address, line starts, shadow ram and output register
// depends on clts_pkg and the assertion macro header
`include "char_lcd_terminal_scroller_unit_assert.svh"

module clts_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clts_pkg::ctrl_cmd_t                 cmd,
	output clts_pkg::dp_sts_t                   sts,
	input  logic [clts_pkg::BYTE_W-1:0]         char_code,
	input  logic                                cfg_valid,
	input  logic [clts_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [clts_pkg::ADDR_W-1:0]         cfg_data,
	input  logic                                lcd_stall,
	output logic                                lcd_valid,
	output logic                                reg_select,
	output logic [clts_pkg::BYTE_W-1:0]         lcd_byte,
	output logic                                long_wait,
	output logic                                last
);

	logic [clts_pkg::BYTE_W-1:0]     char_q;
	logic [clts_pkg::COL_W-1:0]      col_q;
	logic [clts_pkg::ROW_W-1:0]      row_q;
	logic [clts_pkg::ADDR_W-1:0]     waddr_q;
	logic [clts_pkg::X_W-1:0]        x_q;
	logic [clts_pkg::Y_W-1:0]        y_q;
	logic [clts_pkg::ADDR_W-1:0]     ls_q [clts_pkg::NUM_LINES];

	logic [clts_pkg::BYTE_W-1:0]     shadow_q [clts_pkg::RAM_DEPTH];
	logic [clts_pkg::RAM_DEPTH-1:0]  vbits_q;
	logic [clts_pkg::BYTE_W-1:0]     rd_data_q;
	logic                            rd_vld_q;

	logic                            out_vld_q;
	logic                            rs_q;
	logic [clts_pkg::BYTE_W-1:0]     byte_q;
	logic                            long_q;
	logic                            last_q;

	logic [clts_pkg::LINE_IDX_W-1:0] src_row;
	logic [clts_pkg::LINE_IDX_W-1:0] line_idx;
	logic [clts_pkg::ADDR_W-1:0]     ls_cur;
	logic [clts_pkg::ADDR_W-1:0]     addr_x;
	logic [clts_pkg::SUM_W-1:0]      row_sum;
	logic                            emit_rs;
	logic [clts_pkg::BYTE_W-1:0]     emit_byte;
	logic                            emit_long;
	logic                            mem_we;
	logic [clts_pkg::ADDR_W-1:0]     mem_waddr;
	logic [clts_pkg::BYTE_W-1:0]     mem_wdata;
	logic                            data_emit;

	// y + row + 1 - ROWS is the source row of a scroll copy
	assign row_sum = clts_pkg::SUM_W'(y_q) + clts_pkg::SUM_W'(row_q) + clts_pkg::SUM_W'(1);
	assign src_row = clts_pkg::LINE_IDX_W'(row_sum - clts_pkg::SUM_W'(clts_pkg::ROWS));

	always_comb begin
		case (cmd.line_sel)
			clts_pkg::LS_ROW:  line_idx = clts_pkg::LINE_IDX_W'(row_q);
			clts_pkg::LS_Y:    line_idx = clts_pkg::LINE_IDX_W'(y_q);
			clts_pkg::LS_SRC:  line_idx = src_row;
			clts_pkg::LS_LAST: line_idx = clts_pkg::LINE_IDX_W'(clts_pkg::ROWS - 1);
			default:           line_idx = clts_pkg::LINE_IDX_W'(row_q);
		endcase
	end

	assign ls_cur = ls_q[line_idx];
	assign addr_x = ls_cur + clts_pkg::ADDR_W'(x_q);

	always_comb begin
		emit_rs   = 1'b0;
		emit_byte = clts_pkg::CMD_CLEAR;
		emit_long = 1'b0;
		case (cmd.sel)
			clts_pkg::OUT_SETADDR: begin
				emit_byte = clts_pkg::CMD_SET_ADDR | {1'b0, ls_cur};
			end
			clts_pkg::OUT_CLEAR: begin
				emit_byte = clts_pkg::CMD_CLEAR;
				emit_long = 1'b1;
			end
			clts_pkg::OUT_COPY: begin
				emit_rs   = 1'b1;
				emit_byte = rd_vld_q ? rd_data_q : clts_pkg::SPACE_CHAR;
			end
			clts_pkg::OUT_CHAR: begin
				emit_rs   = 1'b1;
				emit_byte = char_q;
			end
			default: begin
				emit_long = 1'b1;
			end
		endcase
	end

	assign data_emit = cmd.emit && (cmd.sel == clts_pkg::OUT_COPY || cmd.sel == clts_pkg::OUT_CHAR);
	assign mem_we    = data_emit || cmd.blank_wr;
	assign mem_waddr = cmd.blank_wr ? addr_x : waddr_q;
	assign mem_wdata = cmd.blank_wr ? clts_pkg::SPACE_CHAR : emit_byte;

	// shadow ram, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			shadow_q[mem_waddr] <= mem_wdata;
		end
		if (cmd.rd_en) begin
			rd_data_q <= shadow_q[addr_x];
			rd_vld_q  <= vbits_q[addr_x];
		end
	end

	// entries not written since reset or clear read as spaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbits_q <= '0;
		end else if (cmd.clr_all) begin
			vbits_q <= '0;
		end else if (mem_we) begin
			vbits_q[mem_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_char) begin
			char_q <= char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < clts_pkg::NUM_LINES; i++) begin
				ls_q[i] <= clts_pkg::LINE_START_RST[i];
			end
		end else if (cfg_valid && cfg_index < clts_pkg::CFG_IDX_W'(clts_pkg::NUM_LINES)) begin
			ls_q[cfg_index[clts_pkg::LINE_IDX_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			waddr_q <= '0;
			x_q     <= '0;
			y_q     <= '0;
		end else begin
			if (cmd.adv) begin
				col_q <= '0;
				if (row_q != clts_pkg::ROW_W'(clts_pkg::ROW_MAX)) begin
					row_q <= row_q + clts_pkg::ROW_W'(1);
				end
			end else if (cmd.home) begin
				col_q <= '0;
				row_q <= clts_pkg::ROW_W'(clts_pkg::ROWS - 1);
			end else if (cmd.emit && cmd.sel == clts_pkg::OUT_CHAR) begin
				col_q <= col_q + clts_pkg::COL_W'(1);
			end
			if (cmd.emit && cmd.sel == clts_pkg::OUT_SETADDR) begin
				waddr_q <= ls_cur;
			end else if (data_emit) begin
				waddr_q <= waddr_q + clts_pkg::ADDR_W'(1);
			end
			if (cmd.x_clr) begin
				x_q <= '0;
			end else if (cmd.x_inc) begin
				x_q <= x_q + clts_pkg::X_W'(1);
			end
			if (cmd.y_clr) begin
				y_q <= '0;
			end else if (cmd.y_inc) begin
				y_q <= y_q + clts_pkg::Y_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (!lcd_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rs_q   <= emit_rs;
			byte_q <= emit_byte;
			long_q <= emit_long;
			last_q <= cmd.last;
		end
	end

	assign lcd_valid  = out_vld_q;
	assign reg_select = rs_q;
	assign lcd_byte   = byte_q;
	assign long_wait  = long_q;
	assign last       = last_q;

	always_comb begin
		sts.is_nl     = (char_q == clts_pkg::NEWLINE_CHAR);
		sts.col_full  = (col_q >= clts_pkg::COL_W'(clts_pkg::COLUMNS));
		sts.row_below = (row_q >= clts_pkg::ROW_W'(clts_pkg::ROWS));
		sts.row_far   = (row_q >= clts_pkg::ROW_W'(clts_pkg::ROW_MAX));
		sts.y_done    = (y_q == clts_pkg::Y_W'(clts_pkg::ROWS));
		sts.copy_row  = (row_sum < clts_pkg::SUM_W'(2 * clts_pkg::ROWS));
		sts.x_last    = (x_q == clts_pkg::X_W'(clts_pkg::COLUMNS - 1));
		sts.out_free  = !out_vld_q || !lcd_stall;
	end

	`CLTS_ASSERT_IMPL(a_last_is_data_or_addr, out_vld_q && last_q && !rs_q, byte_q[7], "final command byte is not a set address")
	`CLTS_ASSERT_IMPL(a_long_only_on_clear, out_vld_q && long_q, !rs_q && byte_q == clts_pkg::CMD_CLEAR, "long wait on a byte other than clear")

endmodule
